[sv/fdo_pkg.sv]
// ---------------------------------------------------------------------------
// Frame-rate overlay package
// Constants, register indexes and the 3x5 digit font shared by the overlay.
// ---------------------------------------------------------------------------
`default_nettype none

package fdo_pkg;

    // Colour written over a pixel that a digit covers.
    localparam logic [31:0] WHITE_PIXEL = 32'hFFFF_FFFF;

    // Rate measurement.
    localparam logic [31:0] UPDATE_MS = 32'd1000;
    localparam logic [9:0]  RATE_CAP  = 10'd999;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Overlay geometry, in screen pixels.
    localparam logic [11:0] TOP_ROW      = 12'd10;
    localparam logic [11:0] GLYPH_HEIGHT = 12'd10;
    localparam logic [14:0] RIGHT_MARGIN = 15'd31;
    localparam logic [14:0] SLOT_PITCH   = 15'd7;
    localparam logic [14:0] GLYPH_WIDTH  = 15'd6;

    // Register widths and indexes of the configuration port.
    localparam int CFG_DATA_W = 13;
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_SCREEN_WIDTH  = 1'd0;
    localparam cfg_index_t REG_SCREEN_HEIGHT = 1'd1;

    // One font row of a digit: bit 2 is the left glyph column.
    function automatic logic [3:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
        logic [19:0] rows;
        logic [3:0]  bits;
        case (digit)
            4'd0:    rows = 20'hEAAAE;
            4'd1:    rows = 20'h4C44E;
            4'd2:    rows = 20'hE2E8E;
            4'd3:    rows = 20'hE2E2E;
            4'd4:    rows = 20'hAAE22;
            4'd5:    rows = 20'hE8E2E;
            4'd6:    rows = 20'hE8EAE;
            4'd7:    rows = 20'hE2222;
            4'd8:    rows = 20'hEAEAE;
            4'd9:    rows = 20'hEAE2E;
            default: rows = 20'h00000;
        endcase
        case (row)
            3'd0:    bits = rows[19:16];
            3'd1:    bits = rows[15:12];
            3'd2:    bits = rows[11:8];
            3'd3:    bits = rows[7:4];
            3'd4:    bits = rows[3:0];
            default: bits = 4'h0;
        endcase
        return bits;
    endfunction

endpackage

`default_nettype wire

[sv/fdo_pix_in_if.sv]
// ---------------------------------------------------------------------------
// Overlay input channel
// Valid/ready channel that carries one raster pixel and its frame timing.
// ---------------------------------------------------------------------------
`default_nettype none

interface fdo_pix_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_in;
    logic        frame_start;
    logic [31:0] time_ms;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_in,
                    output frame_start, output time_ms, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input pixel_in,
                  input frame_start, input time_ms, output ready);
endinterface

`default_nettype wire

[sv/fdo_pix_out_if.sv]
// ---------------------------------------------------------------------------
// Overlay output channel
// Valid/ready channel that carries one pixel after the overlay.
// ---------------------------------------------------------------------------
`default_nettype none

interface fdo_pix_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        overlay_hit;

    modport source (output valid, output pixel_out, output overlay_hit, input ready);
    modport sink (input valid, input pixel_out, input overlay_hit, output ready);
endinterface

`default_nettype wire

[sv/frame_rate_digit_overlay_unit.sv]
// ---------------------------------------------------------------------------
// Frame-rate digit overlay
// Counts frames per second and draws the rate as white digits on the stream.
// ---------------------------------------------------------------------------
// Pixels arrive on in_ch, one beat per pixel, and leave on out_ch in the
// same order, either unchanged or replaced by white where a digit covers
// them. A beat with frame_start set counts one frame; once a second of
// time_ms has passed, the count becomes the shown rate, and that beat is
// already drawn with the new rate.
// The block is a three-stage pipeline: an input register, a register that
// holds the hundreds digit and remainder, and the output register. One beat
// is accepted every cycle while out_ch is ready. Each stage moves on when the
// one after it is empty or moving, so empty stages close up while out_ch
// stalls and in_ch keeps taking beats until all three stages are full.
// Reset empties the pipeline, clears the frame count, timestamp and shown
// rate, and sets the screen to 1024 by 768. The screen size must be written
// on the cfg port while no beat is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module frame_rate_digit_overlay_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire fdo_pkg::cfg_index_t           cfg_index,
    input  wire logic [fdo_pkg::CFG_DATA_W-1:0] cfg_data,
    fdo_pix_in_if.sink                         in_ch,
    fdo_pix_out_if.source                      out_ch
);

    // Configuration registers.
    logic [12:0] width_reg;
    logic [11:0] height_reg;

    // Rate measurement state.
    logic [15:0] frames_reg, frames_next;
    logic [31:0] last_ms_reg, last_ms_next;
    logic [9:0]  rate_reg, rate_next;

    // Pipeline registers.
    logic        s1_valid_reg;
    logic [11:0] s1_x_reg, s1_y_reg;
    logic [31:0] s1_pix_reg;
    logic [9:0]  s1_rate_reg;
    logic        s2_valid_reg;
    logic [11:0] s2_x_reg, s2_y_reg;
    logic [31:0] s2_pix_reg;
    logic [3:0]  s2_hund_reg;
    logic [6:0]  s2_rem_reg;
    logic        s2_zero_reg, s2_ge10_reg, s2_ge100_reg;
    logic        out_valid_reg;
    logic [31:0] out_pix_reg;
    logic        out_hit_reg;

    // Stage enables.
    logic en_out, en_s2, en_s1, accept;

    // Measurement logic.
    logic [15:0] count_inc;
    logic [31:0] elapsed;
    logic [9:0]  count_capped;

    // Second stage logic.
    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [9:0]  rem_full;

    // Overlay logic.
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones_full;
    logic [11:0] ry;
    logic [2:0]  row;
    logic        in_clip;
    logic        hit;
    logic [3:0]  slot_digit [3];
    logic        slot_on [3];
    logic [14:0] rel [3];
    logic [1:0]  col [3];
    logic [3:0]  glyph [3];

    // Handshake: each stage loads when it is empty or drains this cycle.
    assign en_out      = !out_valid_reg || out_ch.ready;
    assign en_s2       = !s2_valid_reg || en_out;
    assign en_s1       = !s1_valid_reg || en_s2;
    assign in_ch.ready = en_s1;
    assign accept      = in_ch.valid && en_s1;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pixel_out   = out_pix_reg;
    assign out_ch.overlay_hit = out_hit_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1024;
            height_reg <= 12'd768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdo_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                fdo_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Frame counting and once-a-second rate update on a frame-start beat.
    always_comb
    begin
        count_inc    = (frames_reg != fdo_pkg::COUNT_MAX) ? frames_reg + 16'd1 : frames_reg;
        elapsed      = in_ch.time_ms - last_ms_reg;
        count_capped = (count_inc > {6'd0, fdo_pkg::RATE_CAP}) ? fdo_pkg::RATE_CAP
                                                               : count_inc[9:0];
        frames_next  = frames_reg;
        last_ms_next = last_ms_reg;
        rate_next    = rate_reg;
        if (accept && in_ch.frame_start)
        begin
            frames_next = count_inc;
            if (elapsed >= fdo_pkg::UPDATE_MS)
            begin
                frames_next  = 16'd0;
                last_ms_next = in_ch.time_ms;
                rate_next    = count_capped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg  <= 16'd0;
            last_ms_reg <= 32'd0;
            rate_reg    <= 10'd0;
        end
        else
        begin
            frames_reg  <= frames_next;
            last_ms_reg <= last_ms_next;
            rate_reg    <= rate_next;
        end
    end

    // Hundreds digit by reciprocal multiply, valid for rates up to 999.
    always_comb
    begin
        hund_prod = {6'd0, s1_rate_reg} * 16'd41;
        hund      = hund_prod[15:12];
        rem_full  = s1_rate_reg - ({6'd0, hund} * 10'd100);
    end

    // Tens and ones digits, then the glyph test for each of the three slots.
    always_comb
    begin
        tens_prod = {8'd0, s2_rem_reg} * 15'd205;
        tens      = tens_prod[14:11];
        ones_full = s2_rem_reg - ({3'd0, tens} * 7'd10);

        slot_digit[0] = s2_zero_reg ? 4'd0 : s2_hund_reg;
        slot_on[0]    = s2_zero_reg || s2_ge100_reg;
        slot_digit[1] = tens;
        slot_on[1]    = s2_ge10_reg;
        slot_digit[2] = ones_full[3:0];
        slot_on[2]    = !s2_zero_reg;

        ry      = s2_y_reg - fdo_pkg::TOP_ROW;
        row     = ry[3:1];
        in_clip = ({1'b0, s2_x_reg} < width_reg) && (s2_y_reg < height_reg)
                  && (ry < fdo_pkg::GLYPH_HEIGHT);

        hit = 1'b0;
        for (int s = 0; s < 3; s++)
        begin
            rel[s]   = {3'd0, s2_x_reg} - {2'd0, width_reg} + fdo_pkg::RIGHT_MARGIN
                       - (fdo_pkg::SLOT_PITCH * 15'(s));
            col[s]   = rel[s][2:1];
            glyph[s] = fdo_pkg::glyph_row(slot_digit[s], row);
            if (slot_on[s] && (rel[s] < fdo_pkg::GLYPH_WIDTH) && glyph[s][2'd2 - col[s]])
            begin
                hit = 1'b1;
            end
        end
        hit = hit && in_clip;
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_s1)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (en_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            s1_x_reg    <= in_ch.pixel_x;
            s1_y_reg    <= in_ch.pixel_y;
            s1_pix_reg  <= in_ch.pixel_in;
            s1_rate_reg <= rate_next;
        end
        if (en_s2)
        begin
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_pix_reg   <= s1_pix_reg;
            s2_hund_reg  <= hund;
            s2_rem_reg   <= rem_full[6:0];
            s2_zero_reg  <= (s1_rate_reg == 10'd0);
            s2_ge10_reg  <= (s1_rate_reg >= 10'd10);
            s2_ge100_reg <= (s1_rate_reg >= 10'd100);
        end
        if (en_out)
        begin
            out_pix_reg <= hit ? fdo_pkg::WHITE_PIXEL : s2_pix_reg;
            out_hit_reg <= hit;
        end
    end

endmodule

`default_nettype wire

[tb/frame_rate_digit_overlay_unit_tb.sv]
// ---------------------------------------------------------------------------
// Frame-rate digit overlay testbench
// Streams pixel beats through the overlay and checks every output beat
// against a cycle-free model of the frame counter, the rate latch and the
// digit font. Screen sizes are changed between phases while the pipeline
// is empty; back-pressure and source gaps are randomized.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_rate_digit_overlay_unit_tb;

    localparam int unsigned CYCLE_LIMIT      = 600000;
    localparam int unsigned PIXELS_PER_SCREEN = 75;
    localparam int unsigned CAP_FRAMES       = 1000;
    localparam int unsigned HOLD_AFTER_BEATS = 120;
    localparam int unsigned HOLD_CYCLES      = 300;

    // Font rows of digits 0 to 9, row 0 in the top nibble.
    localparam logic [0:9][19:0] NUMERAL_ROWS = {
        20'hEAAAE, 20'h4C44E, 20'hE2E8E, 20'hE2E2E, 20'hAAE22,
        20'hE8E2E, 20'hE8EAE, 20'hE2222, 20'hEAEAE, 20'hEAE2E
    };

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] color;
        logic        frame_start;
        logic [31:0] time_ms;
    } pixel_beat_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        hit;
    } overlay_result_t;

    logic                 clk;
    logic                 rst_n = 1'b1;
    logic                 cfg_we = 1'b0;
    fdo_pkg::cfg_index_t  cfg_index = fdo_pkg::REG_SCREEN_WIDTH;
    logic [12:0]          cfg_data = '0;

    fdo_pix_in_if  pix_in ();
    fdo_pix_out_if pix_out ();

    frame_rate_digit_overlay_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (pix_in),
        .out_ch    (pix_out)
    );

    // Model state: screen size, frame counter and the latched rate.
    logic [12:0] screen_w     = 13'd1024;
    logic [11:0] screen_h     = 12'd768;
    logic [15:0] frames_seen  = '0;
    logic [31:0] last_rate_ms = '0;
    logic [9:0]  rate_shown   = '0;

    // Stimulus shaping: the generator keeps its own view of the rate epochs.
    logic [31:0] gen_now      = '0;
    logic [31:0] gen_last     = '0;
    int unsigned epoch_frames = 0;
    int unsigned epoch_target = 5;

    pixel_beat_t     pixel_backlog[$];
    overlay_result_t expected_pixels[$];

    int          sender_gap_pct = 0;
    int          ready_gap_pct  = 0;
    int          mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;

    // Digit shown in a slot, or -1 when the slot stays blank.
    function automatic int slot_digit(input int slot);
        int r;
        r = rate_shown;
        if (r > 999)
            r = 999;
        if (r == 0)
            return (slot == 0) ? 0 : -1;
        case (slot)
            2:       return r % 10;
            1:       return (r >= 10) ? (r / 10) % 10 : -1;
            default: return (r >= 100) ? r / 100 : -1;
        endcase
    endfunction

    // True when a digit glyph lights this pixel; columns wrap modulo 2^32.
    function automatic logic digit_covers(input logic [11:0] px, input logic [11:0] py);
        int unsigned row_u;
        int unsigned base;
        int unsigned rel;
        int          digit;
        if (px >= screen_w || py >= screen_h)
            return 1'b0;
        row_u = py;
        row_u = row_u - 10;
        if (row_u >= 10)
            return 1'b0;
        row_u = row_u / 2;
        for (int slot = 0; slot < 3; slot++)
        begin
            base = screen_w;
            base = base - 31 + 7 * slot;
            rel  = px;
            rel  = rel - base;
            if (rel < 6)
            begin
                digit = slot_digit(slot);
                if (digit >= 0)
                begin
                    if (NUMERAL_ROWS[digit][(4 - row_u) * 4 + 2 - rel / 2])
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Advances the frame counter for one beat and returns the overlaid pixel.
    function automatic overlay_result_t apply_overlay(input pixel_beat_t beat);
        overlay_result_t res;
        if (beat.frame_start)
        begin
            if (frames_seen != fdo_pkg::COUNT_MAX)
                frames_seen = frames_seen + 16'd1;
            if (beat.time_ms - last_rate_ms >= fdo_pkg::UPDATE_MS)
            begin
                rate_shown   = (frames_seen > 16'(fdo_pkg::RATE_CAP)) ?
                               fdo_pkg::RATE_CAP : frames_seen[9:0];
                frames_seen  = '0;
                last_rate_ms = beat.time_ms;
            end
        end
        res.hit   = digit_covers(beat.x, beat.y);
        res.pixel = res.hit ? fdo_pkg::WHITE_PIXEL : beat.color;
        return res;
    endfunction

    // Queues one pixel beat and tracks the epochs the generator aims for.
    task automatic queue_pixel(input logic [11:0] x, input logic [11:0] y,
                               input logic [31:0] color, input logic fs,
                               input logic [31:0] t);
        pixel_beat_t beat;
        beat = '{x, y, color, fs, t};
        pixel_backlog.push_back(beat);
        if (fs)
        begin
            epoch_frames++;
            if (t - gen_last >= 32'd1000)
            begin
                gen_last     = t;
                epoch_frames = 0;
            end
            gen_now = t;
        end
    endtask

    // Frames per epoch: mostly one or two digits, sometimes three.
    function automatic int unsigned pick_epoch_target();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom_range(1, 9);
        else if (pick < 85)
            return $urandom_range(10, 99);
        return $urandom_range(100, 180);
    endfunction

    // Random mix of frame starts, pixels near the digits and raster noise.
    task automatic random_stream(input int unsigned count, input int unsigned width);
        int unsigned kind;
        int unsigned x;
        logic [31:0] t;
        for (int unsigned i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                if (epoch_frames + 1 < epoch_target)
                begin
                    // Inside an epoch: time creeps forward, at most to 999 ms.
                    if ($urandom_range(0, 19) == 0)
                        t = gen_last + 32'd999;
                    else
                    begin
                        t = gen_now + $urandom_range(0, 2);
                        if (t - gen_last >= 32'd1000)
                            t = gen_now;
                    end
                end
                else
                begin
                    // End of an epoch, with backward and wild timestamps now and then.
                    case ($urandom_range(0, 9))
                        0:       t = gen_now - $urandom_range(1, 100000);
                        1:       t = $urandom();
                        default: t = gen_last + 32'd1000 + $urandom_range(0, 3);
                    endcase
                    epoch_target = pick_epoch_target();
                end
                if ($urandom_range(0, 9) < 7)
                    queue_pixel('0, '0, $urandom(), 1'b1, t);
                else
                    queue_pixel(12'($urandom()), 12'($urandom()), $urandom(), 1'b1, t);
            end
            else if (kind < 85)
            begin
                x = width - 33 + $urandom_range(0, 40);
                queue_pixel(x[11:0], 12'(7 + $urandom_range(0, 15)), $urandom(), 1'b0,
                            $urandom());
            end
            else
                queue_pixel(12'($urandom()), 12'($urandom()), $urandom(), 1'b0, $urandom());
        end
    endtask

    // Waits until every queued beat has been sent and every result seen.
    task automatic drain_pipeline();
        while (pixel_backlog.size() != 0 || pix_in.valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes both screen registers while the pipeline is empty.
    task automatic write_screen(input logic [12:0] width, input logic [12:0] height_word);
        drain_pipeline();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= fdo_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_index <= fdo_pkg::REG_SCREEN_HEIGHT;
        cfg_data  <= height_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
        screen_w = width;
        screen_h = height_word[11:0];
        @(negedge clk);
    endtask

    // Clock and the single reset at the start of the run.
    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Source side: one beat offered at a time, predicted when it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        pixel_beat_t beat;
        if (!rst_n)
        begin
            pix_in.valid       <= 1'b0;
            pix_in.pixel_x     <= '0;
            pix_in.pixel_y     <= '0;
            pix_in.pixel_in    <= '0;
            pix_in.frame_start <= 1'b0;
            pix_in.time_ms     <= '0;
        end
        else if (!pix_in.valid || pix_in.ready)
        begin
            if (pix_in.valid)
            begin
                beat = '{pix_in.pixel_x, pix_in.pixel_y, pix_in.pixel_in,
                         pix_in.frame_start, pix_in.time_ms};
                expected_pixels.push_back(apply_overlay(beat));
            end
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct)
            begin
                beat = pixel_backlog.pop_front();
                pix_in.valid       <= 1'b1;
                pix_in.pixel_x     <= beat.x;
                pix_in.pixel_y     <= beat.y;
                pix_in.pixel_in    <= beat.color;
                pix_in.frame_start <= beat.frame_start;
                pix_in.time_ms     <= beat.time_ms;
            end
            else
                pix_in.valid <= 1'b0;
        end
    end

    // Sink side: checks each result beat and paces ready, with one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : check_pixels
        overlay_result_t want;
        if (!rst_n)
            pix_out.ready <= 1'b0;
        else
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result beat: pixel_out %h overlay_hit %b",
                           pix_out.pixel_out, pix_out.overlay_hit);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix_out.pixel_out !== want.pixel)
                    begin
                        $error("pixel_out: expected %h, actual %h", want.pixel,
                               pix_out.pixel_out);
                        mismatches++;
                    end
                    if (pix_out.overlay_hit !== want.hit)
                    begin
                        $error("overlay_hit: expected %b, actual %b", want.hit,
                               pix_out.overlay_hit);
                        mismatches++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AFTER_BEATS)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end
            else
                pix_out.ready <= ($urandom_range(0, 99) >= ready_gap_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin : run_sequence
        int unsigned widths[8];
        int unsigned heights[8];
        logic [12:0] height_word;
        int unsigned x;
        widths  = '{640, 4096, 1024, 20, 0, 8191, 31, 0};
        heights = '{480, 2160, 15, 12, 0, 4095, 20, 0};
        widths[7]  = $urandom_range(640, 4096);
        heights[7] = $urandom_range(480, 2160);

        @(posedge rst_n);
        @(negedge clk);
        sender_gap_pct = 20;
        ready_gap_pct  = 64;

        // Directed: field extremes, the lone zero of a fresh reset, and the
        // update boundary with wrapped and backward timestamps.
        queue_pixel(12'd0, 12'd0, 32'h0000_0000, 1'b0, 32'h0000_0000);
        queue_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        queue_pixel(12'd993, 12'd10, 32'h1234_5678, 1'b0, 32'h0);
        queue_pixel(12'd994, 12'd19, 32'h0000_0000, 1'b0, 32'h0);
        queue_pixel(12'd998, 12'd14, 32'hAAAA_5555, 1'b0, 32'h0);
        queue_pixel(12'd992, 12'd10, 32'h5555_AAAA, 1'b0, 32'h0);
        queue_pixel(12'd993, 12'd9, 32'h0F0F_0F0F, 1'b0, 32'h0);
        queue_pixel(12'd993, 12'd20, 32'hF0F0_F0F0, 1'b0, 32'h0);
        queue_pixel(12'd1001, 12'd10, 32'h0000_0001, 1'b0, 32'h0);
        queue_pixel(12'd0, 12'd0, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
        queue_pixel(12'd1008, 12'd12, 32'h0000_00FF, 1'b0, 32'h0);
        queue_pixel(12'd1007, 12'd18, 32'h0000_FF00, 1'b0, 32'h0);
        queue_pixel(12'd0, 12'd0, 32'h00FF_0000, 1'b1, 32'd0);
        queue_pixel(12'd0, 12'd0, 32'hFF00_0000, 1'b1, 32'd998);
        queue_pixel(12'd1009, 12'd10, 32'h0000_0002, 1'b0, 32'h0);
        queue_pixel(12'd0, 12'd0, 32'h0000_0004, 1'b1, 32'd999);
        queue_pixel(12'd1009, 12'd10, 32'h0000_0008, 1'b0, 32'h0);
        queue_pixel(12'd1007, 12'd16, 32'h0000_0010, 1'b0, 32'h0);
        queue_pixel(12'd0, 12'd0, 32'h0000_0020, 1'b1, 32'd5);
        queue_pixel(12'd1008, 12'd12, 32'h0000_0040, 1'b0, 32'h0);

        // Random phases over several screen sizes, the idling pattern
        // changing every few phases.
        for (int s = 0; s < 8; s++)
        begin
            if (s == 3)
            begin
                drain_pipeline();
                sender_gap_pct = 64;
                ready_gap_pct  = 20;
            end
            else if (s == 6)
            begin
                drain_pipeline();
                sender_gap_pct = 0;
                ready_gap_pct  = 0;
            end
            height_word = {1'b0, 12'(heights[s])};
            if (s == 7)
                height_word[12] = 1'($urandom_range(0, 1));
            write_screen(13'(widths[s]), height_word);
            random_stream(PIXELS_PER_SCREEN, widths[s]);
        end

        // Run the frame count past the cap, then show the capped rate.
        write_screen(13'd1024, 13'd768);
        for (int unsigned i = 0; i < CAP_FRAMES; i++)
        begin
            while (pixel_backlog.size() > 256)
                @(negedge clk);
            queue_pixel('0, '0, $urandom(), 1'b1, gen_last);
        end
        queue_pixel('0, '0, $urandom(), 1'b1, gen_last + 32'd1000);
        for (int unsigned i = 0; i < 40; i++)
        begin
            x = 1024 - 33 + $urandom_range(0, 40);
            queue_pixel(x[11:0], 12'(7 + $urandom_range(0, 15)), $urandom(), 1'b0,
                        $urandom());
        end

        drain_pipeline();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
